### rtl/cfbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame batch framer package
// Shared types, constants and helper functions for the frame batching block.
// ----------------------------------------------------------------------------
package cfbf_pkg;

  localparam int BatchFramesDef = 60;
  localparam int IdSpace        = 2048;
  localparam int IdW            = 11;
  localparam int DlcW           = 4;
  localparam int DataW          = 64;
  localparam int SeqW           = 16;
  localparam int IntervalW      = 10;
  localparam int MaxDlc         = 8;
  localparam logic [IntervalW-1:0] IntervalRst = IntervalW'(20);

  typedef enum logic [1:0] {
    ReqFrame = 2'd0,
    ReqTick  = 2'd1,
    ReqWrite = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IdW-1:0]   can_id;
    logic [DlcW-1:0]  frame_dlc;
    logic [DataW-1:0] frame_data;
    logic             allow_id;
    logic             clients_present;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]   rec_can_id;
    logic [DlcW-1:0]  rec_dlc;
    logic [DataW-1:0] rec_data;
    logic [SeqW-1:0]  rec_seq;
    logic             last_in_batch;
  } rec_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DlcW-1:0]  dlc;
    logic [DataW-1:0] data;
    logic [SeqW-1:0]  seq;
  } entry_t;

  function automatic logic [DlcW-1:0] clamp_dlc(input logic [DlcW-1:0] dlc);
    return (dlc > DlcW'(MaxDlc)) ? DlcW'(MaxDlc) : dlc;
  endfunction

  function automatic logic [DataW-1:0] byte_mask(input logic [DlcW-1:0] dlc);
    logic [DataW-1:0] mask;
    for (int k = 0; k < DataW / 8; k++) begin
      mask[8*k +: 8] = (DlcW'(k) < dlc) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

### rtl/cfbf_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame batch framer channel interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cfbf_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### rtl/can_frame_batch_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame batch framer core
// Filters frames through an identifier whitelist, stamps them with a sequence
// number, collects them in a batch memory and flushes it periodically or when full.
// ----------------------------------------------------------------------------
// Ticks, whitelist writes and unused requests are handled in the idle state.
// A frame takes two steps: idle reads the whitelist memory, lookup stores it or starts a flush.
// A flush streams one record per cycle from the batch memory read port while
// the output is not stalled.
// After reset all 2048 whitelist entries are cleared one entry per cycle, during
// which no request is accepted; configuration writes are taken at once.
module can_frame_batch_framer_core #(
  parameter int BATCH_FRAMES = cfbf_pkg::BatchFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfbf_chan_if.sink   cfg_i,
  cfbf_chan_if.sink   req_i,
  cfbf_chan_if.source rec_o
);

  localparam int FillW  = $clog2(BATCH_FRAMES + 1);
  localparam int IdxW   = (BATCH_FRAMES > 1) ? $clog2(BATCH_FRAMES) : 1;
  localparam int EntryW = $bits(cfbf_pkg::entry_t);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup,
    StDrain
  } state_e;

  state_e                             state_q, state_d;
  logic [cfbf_pkg::IdW-1:0]           clr_cnt_q, clr_cnt_d;
  logic [FillW-1:0]                   fill_q, fill_d;
  logic [FillW-1:0]                   iss_cnt_q, iss_cnt_d;
  logic [cfbf_pkg::SeqW-1:0]          seq_q, seq_d;
  logic [cfbf_pkg::IntervalW-1:0]     tick_q, tick_d;
  logic [cfbf_pkg::IntervalW-1:0]     intv_q, intv_d;
  logic                               store_pend_q, store_pend_d;
  logic                               rd_pend_q, rd_pend_d;
  logic                               rd_last_q, rd_last_d;
  logic                               out_valid_q, out_valid_d;
  cfbf_pkg::rec_t                     out_q, out_d;
  logic [cfbf_pkg::IdW-1:0]           id_q, id_d;
  logic [cfbf_pkg::DlcW-1:0]          dlc_q, dlc_d;
  logic [cfbf_pkg::DataW-1:0]         data_q, data_d;
  logic                               present_q, present_d;

  cfbf_pkg::req_t                     req;
  logic                               req_acc;
  logic                               full;
  logic [cfbf_pkg::IntervalW-1:0]     tick_inc;
  logic [cfbf_pkg::DlcW-1:0]          dlc_clamped;

  logic                               al_we, al_wdata, al_re, al_rdata;
  logic [cfbf_pkg::IdW-1:0]           al_waddr;

  logic                               bt_we, bt_re;
  logic [IdxW-1:0]                    bt_waddr;
  cfbf_pkg::entry_t                   bt_wdata, bt_rdata;
  logic [EntryW-1:0]                  bt_rdata_raw;

  logic                               load, issue, drain_done;

  assign req         = req_i.data;
  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign full        = (fill_q == FillW'(BATCH_FRAMES));
  assign tick_inc    = tick_q + 1'b1;
  assign dlc_clamped = cfbf_pkg::clamp_dlc(req.frame_dlc);

  assign rec_o.valid = out_valid_q;
  assign rec_o.data  = out_q;

  assign al_we    = (state_q == StClear) ||
                    (req_acc && (req.req_type == cfbf_pkg::ReqWrite));
  assign al_waddr = (state_q == StClear) ? clr_cnt_q : req.can_id;
  assign al_wdata = (state_q == StClear) ? 1'b0 : req.allow_id;
  assign al_re    = req_acc && (req.req_type == cfbf_pkg::ReqFrame);

  cfbf_ram #(
    .Width (1),
    .Depth (cfbf_pkg::IdSpace)
  ) u_allow_ram (
    .clk_i   (clk_i),
    .we_i    (al_we),
    .waddr_i (al_waddr),
    .wdata_i (al_wdata),
    .re_i    (al_re),
    .raddr_i (req.can_id),
    .rdata_o (al_rdata)
  );

  assign load       = rd_pend_q && (!out_valid_q || rec_o.ready);
  assign issue      = (state_q == StDrain) && (iss_cnt_q != fill_q) && (!rd_pend_q || load);
  assign drain_done = (state_q == StDrain) && (iss_cnt_q == fill_q) && (!rd_pend_q || load);
  assign bt_re      = issue;

  assign bt_wdata.id   = id_q;
  assign bt_wdata.dlc  = dlc_q;
  assign bt_wdata.data = data_q;
  assign bt_wdata.seq  = seq_q;
  assign bt_rdata      = cfbf_pkg::entry_t'(bt_rdata_raw);

  cfbf_ram #(
    .Width (EntryW),
    .Depth (BATCH_FRAMES)
  ) u_batch_ram (
    .clk_i   (clk_i),
    .we_i    (bt_we),
    .waddr_i (bt_waddr),
    .wdata_i (bt_wdata),
    .re_i    (bt_re),
    .raddr_i (iss_cnt_q[IdxW-1:0]),
    .rdata_o (bt_rdata_raw)
  );

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    fill_d       = fill_q;
    iss_cnt_d    = iss_cnt_q;
    seq_d        = seq_q;
    tick_d       = tick_q;
    intv_d       = intv_q;
    store_pend_d = store_pend_q;
    rd_pend_d    = rd_pend_q;
    rd_last_d    = rd_last_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    id_d         = id_q;
    dlc_d        = dlc_q;
    data_d       = data_q;
    present_d    = present_q;
    bt_we        = 1'b0;
    bt_waddr     = fill_q[IdxW-1:0];

    if (cfg_i.valid) begin
      intv_d = cfg_i.data;
    end

    if (load) begin
      out_d.rec_can_id    = bt_rdata.id;
      out_d.rec_dlc       = bt_rdata.dlc;
      out_d.rec_data      = bt_rdata.data;
      out_d.rec_seq       = bt_rdata.seq;
      out_d.last_in_batch = rd_last_q;
      out_valid_d         = 1'b1;
    end else if (rec_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (issue) begin
      rd_pend_d = 1'b1;
      rd_last_d = ((iss_cnt_q + 1'b1) == fill_q);
      iss_cnt_d = iss_cnt_q + 1'b1;
    end else if (load) begin
      rd_pend_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == cfbf_pkg::IdW'(cfbf_pkg::IdSpace - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_acc) begin
          case (req.req_type)
            cfbf_pkg::ReqFrame: begin
              id_d      = req.can_id;
              dlc_d     = dlc_clamped;
              data_d    = req.frame_data & cfbf_pkg::byte_mask(dlc_clamped);
              present_d = req.clients_present;
              state_d   = StLookup;
            end
            cfbf_pkg::ReqTick: begin
              if (tick_inc >= intv_q) begin
                tick_d = '0;
                if (fill_q != '0) begin
                  if (req.clients_present) begin
                    store_pend_d = 1'b0;
                    iss_cnt_d    = '0;
                    state_d      = StDrain;
                  end else begin
                    fill_d = '0;
                  end
                end
              end else begin
                tick_d = tick_inc;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StLookup: begin
        state_d = StIdle;
        if (al_rdata) begin
          if (full && present_q) begin
            store_pend_d = 1'b1;
            iss_cnt_d    = '0;
            state_d      = StDrain;
          end else begin
            bt_we    = 1'b1;
            bt_waddr = full ? '0 : fill_q[IdxW-1:0];
            fill_d   = full ? FillW'(1) : fill_q + 1'b1;
            seq_d    = seq_q + 1'b1;
          end
        end
      end
      StDrain: begin
        if (drain_done) begin
          state_d = StIdle;
          if (store_pend_q) begin
            bt_we    = 1'b1;
            bt_waddr = '0;
            fill_d   = FillW'(1);
            seq_d    = seq_q + 1'b1;
          end else begin
            fill_d = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_cnt_q    <= '0;
      fill_q       <= '0;
      iss_cnt_q    <= '0;
      seq_q        <= '0;
      tick_q       <= '0;
      intv_q       <= cfbf_pkg::IntervalRst;
      store_pend_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      id_q         <= '0;
      dlc_q        <= '0;
      data_q       <= '0;
      present_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      fill_q       <= fill_d;
      iss_cnt_q    <= iss_cnt_d;
      seq_q        <= seq_d;
      tick_q       <= tick_d;
      intv_q       <= intv_d;
      store_pend_q <= store_pend_d;
      rd_pend_q    <= rd_pend_d;
      rd_last_q    <= rd_last_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      id_q         <= id_d;
      dlc_q        <= dlc_d;
      data_q       <= data_d;
      present_q    <= present_d;
    end
  end

endmodule

### rtl/cfbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame batch framer RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cfbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame batch framer checker
// Port-level assertions on the record output and the request channel.
// ----------------------------------------------------------------------------
module cfbf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_ready_i,
  input logic           rec_valid_i,
  input logic           rec_ready_i,
  input cfbf_pkg::rec_t rec_data_i
);

  // A pending record is neither withdrawn nor changed until its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && !rec_ready_i |=> rec_valid_i)
    else $error("record withdrawn before its transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && !rec_ready_i |=> $stable(rec_data_i))
    else $error("record changed while stalled");

  // Records carry a clamped length and no data beyond it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> (rec_data_i.rec_dlc <= cfbf_pkg::DlcW'(cfbf_pkg::MaxDlc)) &&
      ((rec_data_i.rec_data & ~cfbf_pkg::byte_mask(rec_data_i.rec_dlc)) == '0))
    else $error("record length or data out of range");

  // The whitelist is being cleared right after reset, so no request is taken.
  assert property (@(posedge clk_i)
    !rst_ni |=> !req_ready_i)
    else $error("request accepted during whitelist clearing");

endmodule

bind can_frame_batch_framer_core cfbf_checker u_cfbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rec_valid_i (rec_o.valid),
  .rec_ready_i (rec_o.ready),
  .rec_data_i  (rec_o.data)
);
